FILE: rtl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// shared types, constants and helpers of the streaming sobel edge filter
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned NUM_CHAN     = 3;
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned CFG_WIDTH_W  = 12;
  localparam int unsigned CFG_HEIGHT_W = 13;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_INDEX_W  = 8;
  localparam int unsigned MIN_DIM      = 3;
  localparam int unsigned MAX_HEIGHT   = 4096;
  localparam int unsigned SAT_LIMIT    = 255;
  localparam int unsigned RESET_WIDTH  = 640;
  localparam int unsigned RESET_HEIGHT = 480;
  localparam int unsigned TAP_W        = 10;
  localparam int unsigned GRAD_W       = 11;

  typedef logic [CHAN_W-1:0] chan_t;

  // red in the low byte, alpha in the high byte
  typedef struct packed {
    chan_t alpha;
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  typedef logic signed [GRAD_W-1:0] grad_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH  = 8'd0,
    CFG_FRAME_HEIGHT = 8'd1
  } cfg_index_e;

  // 1-2-1 weighted sum of three taps
  function automatic logic [TAP_W-1:0] tap_sum(chan_t a, chan_t b, chan_t c);
    logic [TAP_W-1:0] s;
    s = TAP_W'(a) + TAP_W'({b, 1'b0}) + TAP_W'(c);
    return s;
  endfunction

endpackage

FILE: rtl/sobel_ram.sv
// ----------------------------------------------------------------------------
// sobel_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sobel_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sobel_edge_stream_filter_top.sv
// ----------------------------------------------------------------------------
// sobel_edge_stream_filter_top
// 3x3 sobel edge filter on an rgba raster stream, l1 magnitude per channel
// path: the beat that completes a window passes the read, window shift,
//   gradient and magnitude registers before its result beat is valid
// throughput: one pixel per clock unless the output is stalled, set by the
//   row memories doing one read and one write-back per cycle
// reset: counters, window, valid bits cleared, size registers to 640 x 480;
//   row memories are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module sobel_edge_stream_filter_top
  import sobel_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // pixel input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
  // result output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [31:0]            m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                   m_axis_tlast,  // frame_last
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // size registers and raster position
  logic [CFG_WIDTH_W-1:0]  cfg_width_q;
  logic [CFG_HEIGHT_W-1:0] cfg_height_q;
  logic [ColW-1:0]         col_q, col_d;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [ColW-1:0]         w_m1;
  logic [ROW_W-1:0]        h_m1;
  logic                    cfg_wr;
  logic                    in_acc;

  // pipeline handshake
  logic ready1, ready2, ready3, ready_o;
  logic adv1;

  // stage 1: pixel waiting for its row memory read
  logic            v1_q;
  pixel_t          cur_q;
  logic [ColW-1:0] col1_q;
  logic            emit1_q;
  logic            last1_q;

  // stage 2: window
  logic   v2_q;
  pixel_t win_q [9];
  logic   last2_q;

  // stage 3: gradients
  logic   v3_q;
  grad_t  gx_q [NUM_CHAN];
  grad_t  gy_q [NUM_CHAN];
  grad_t  gx_d [NUM_CHAN];
  grad_t  gy_d [NUM_CHAN];
  chan_t  alpha3_q;
  logic   last3_q;

  // output register
  logic   m_valid_q;
  pixel_t m_data_q;
  pixel_t m_data_d;
  logic   m_last_q;

  // row memories: a is the previous row, b the row before it
  logic [31:0] up1, up2;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // clamp the configured sizes into the supported range
  always_comb begin
    if (cfg_width_q < CFG_WIDTH_W'(MIN_DIM)) begin
      w_m1 = ColW'(MIN_DIM - 1);
    end else if (32'(cfg_width_q) > MAX_WIDTH) begin
      w_m1 = ColW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = ColW'(cfg_width_q - CFG_WIDTH_W'(1));
    end
    if (cfg_height_q < CFG_HEIGHT_W'(MIN_DIM)) begin
      h_m1 = ROW_W'(MIN_DIM - 1);
    end else if (32'(cfg_height_q) > MAX_HEIGHT) begin
      h_m1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = ROW_W'(cfg_height_q - CFG_HEIGHT_W'(1));
    end
  end

  // elastic pipeline: a stage takes a beat when empty or when it moves on
  assign ready_o       = !m_valid_q || m_axis_tready;
  assign ready3        = !v3_q || ready_o;
  assign ready2        = !v2_q || ready3;
  assign ready1        = !v1_q || ready2;
  assign s_axis_tready = ready1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign adv1          = v1_q && ready2;

  // raster position of the next pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_q == w_m1) begin
        col_d = '0;
        row_d = (row_q == h_m1) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CFG_WIDTH_W'(RESET_WIDTH);
      cfg_height_q <= CFG_HEIGHT_W'(RESET_HEIGHT);
      col_q        <= '0;
      row_q        <= '0;
    end else if (cfg_wr) begin
      // any known register restarts the frame
      case (cfg_index_i)
        CFG_FRAME_WIDTH: begin
          cfg_width_q <= cfg_data_i[CFG_WIDTH_W-1:0];
          col_q       <= '0;
          row_q       <= '0;
        end
        CFG_FRAME_HEIGHT: begin
          cfg_height_q <= cfg_data_i;
          col_q        <= '0;
          row_q        <= '0;
        end
        default: begin
          col_q <= col_d;
          row_q <= row_d;
        end
      endcase
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // read both rows at the column of the accepted pixel, write back when it
  // leaves stage 1, at the same column; consecutive pixels never share a column
  sobel_ram #(
    .WIDTH (32),
    .DEPTH (MAX_WIDTH)
  ) u_row_a (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (col1_q),
    .wdata_i (cur_q),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (up1)
  );

  sobel_ram #(
    .WIDTH (32),
    .DEPTH (MAX_WIDTH)
  ) u_row_b (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (col1_q),
    .wdata_i (up1),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (up2)
  );

  // stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready1) begin
      v1_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q   <= s_axis_tdata;
      col1_q  <= col_q;
      emit1_q <= (row_q >= ROW_W'(2)) && (col_q >= ColW'(2));
      last1_q <= (row_q == h_m1) && (col_q == w_m1);
    end
  end

  // stage 2: every pixel shifts the window, only interior ones go on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (ready2) begin
        v2_q <= v1_q && emit1_q;
      end
      if (adv1) begin
        last2_q <= last1_q;
        for (int i = 0; i < 3; i++) begin
          win_q[i*3]   <= win_q[i*3+1];
          win_q[i*3+1] <= win_q[i*3+2];
        end
        win_q[2] <= up2;
        win_q[5] <= up1;
        win_q[8] <= cur_q;
      end
    end
  end

  // stage 3: horizontal and vertical gradients per color channel
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      gx_d[k] = $signed({1'b0, tap_sum(win_q[0][8*k +: 8], win_q[3][8*k +: 8],
                                       win_q[6][8*k +: 8])})
              - $signed({1'b0, tap_sum(win_q[2][8*k +: 8], win_q[5][8*k +: 8],
                                       win_q[8][8*k +: 8])});
      gy_d[k] = $signed({1'b0, tap_sum(win_q[0][8*k +: 8], win_q[1][8*k +: 8],
                                       win_q[2][8*k +: 8])})
              - $signed({1'b0, tap_sum(win_q[6][8*k +: 8], win_q[7][8*k +: 8],
                                       win_q[8][8*k +: 8])});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ready3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && ready3) begin
      gx_q     <= gx_d;
      gy_q     <= gy_d;
      alpha3_q <= win_q[4].alpha;
      last3_q  <= last2_q;
    end
  end

  // output stage: |gx| + |gy| saturated to a byte
  always_comb begin
    logic [TAP_W-1:0]  ax;
    logic [TAP_W-1:0]  ay;
    logic [GRAD_W-1:0] mag;
    m_data_d = '0;
    for (int k = 0; k < NUM_CHAN; k++) begin
      ax  = gx_q[k][GRAD_W-1] ? TAP_W'(-gx_q[k]) : TAP_W'(gx_q[k]);
      ay  = gy_q[k][GRAD_W-1] ? TAP_W'(-gy_q[k]) : TAP_W'(gy_q[k]);
      mag = GRAD_W'(ax) + GRAD_W'(ay);
      m_data_d[8*k +: 8] = (mag > GRAD_W'(SAT_LIMIT)) ? CHAN_W'(SAT_LIMIT)
                                                        : mag[CHAN_W-1:0];
    end
    m_data_d.alpha = alpha3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ready_o) begin
      m_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && ready_o) begin
      m_data_q <= m_data_d;
      m_last_q <= last3_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // write-back never collides with the read of the following pixel
  a_no_rmw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv1 && in_acc |-> col1_q != col_q)
    else $error("row memory read and write-back hit the same column");

  // the frame's last pixel is always an interior one
  a_last_is_interior : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && last1_q |-> emit1_q)
    else $error("last pixel of frame not marked for output");

  // raster position stays inside the clamped frame
  a_pos_in_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_m1 && row_q <= h_m1)
    else $error("raster position outside frame");

  // the window only shifts when the next stage can take its contents
  a_window_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !ready3 |=> $stable(win_q[4]) && v2_q)
    else $error("window changed under a stalled beat");

endmodule
